FILE: design/ecg_heart_rate_detector_unit_macros.svh
// Assertion macros used by the heart rate detector top level.
`ifndef ECG_HEART_RATE_DETECTOR_UNIT_MACROS_SVH
`define ECG_HEART_RATE_DETECTOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define EHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heart rate detector assertion failed");
`define EHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heart rate detector assertion failed");
`else
`define EHR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EHR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/ehr_pkg.sv
// Package with widths, constants and types of the heart rate detector.
package ehr_pkg;

    localparam int SAMPLE_W           = 12;
    localparam int THRESH_W           = 12;
    localparam int SPACING_W          = 16;
    localparam int RATE_W             = 12;
    localparam int BPM_W              = 8;
    localparam int STAMP_W            = 32;

    localparam int AVERAGE_TAPS       = 5;
    localparam int INTERVAL_HISTORY   = 8;

    localparam int TAP_SUM_W          = SAMPLE_W + $clog2(AVERAGE_TAPS);
    localparam int HIST_IDX_W         = $clog2(INTERVAL_HISTORY);
    localparam int RATE_MIN_INTERVALS = 3;
    localparam int COUNT_CAP          = (INTERVAL_HISTORY > RATE_MIN_INTERVALS) ?
                                        INTERVAL_HISTORY : RATE_MIN_INTERVALS;
    localparam int COUNT_W            = $clog2(COUNT_CAP + 1);
    localparam int IVL_SUM_W          = STAMP_W + $clog2(INTERVAL_HISTORY);

    // The window mean is a multiply by a rounded-up reciprocal, exact for every window sum.
    localparam int AVG_SHIFT          = TAP_SUM_W + $clog2(AVERAGE_TAPS);
    localparam int AVG_RECIP          = ((1 << AVG_SHIFT) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;
    localparam int AVG_RECIP_W        = TAP_SUM_W + 1;
    localparam int AVG_PROD_W         = TAP_SUM_W + AVG_RECIP_W;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int BPM_NUM_W          = RATE_W + 6;
    localparam int BPM_MIN            = 40;
    localparam int BPM_MAX            = 200;

    localparam int DIV_W              = IVL_SUM_W;
    localparam int DIV_CNT_W          = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;

    localparam int THRESH_RESET       = 2048;
    localparam int SPACING_RESET      = 50;
    localparam int RATE_RESET         = 250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SPACING   = 2'd1,
        CFG_RATE      = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_SUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_BPM_GO,
        S_BPM_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/ehr_sample_if.sv
// Channel interface that carries one raw ECG sample word.
interface ehr_sample_if;
    import ehr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] ecg_sample;

    modport source (output valid, output ecg_sample, input ready);
    modport sink   (input valid, input ecg_sample, output ready);
endinterface

FILE: design/ehr_result_if.sv
// Channel interface that carries one result word of the detector.
interface ehr_result_if;
    import ehr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered_sample;
    logic                peak_found;
    logic [BPM_W-1:0]    beats_per_minute;

    modport source (output valid, output filtered_sample, output peak_found,
                    output beats_per_minute, input ready);
    modport sink   (input valid, input filtered_sample, input peak_found,
                    input beats_per_minute, output ready);
endinterface

FILE: design/ehr_cfg_if.sv
// Configuration write channel interface with register index and data.
interface ehr_cfg_if;
    import ehr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/ecg_heart_rate_detector_unit.sv
// Top level of the ECG R-peak heart rate detector.
//
// Channel    Role   Word
// sample_ch  sink   ecg_sample
// result_ch  source filtered_sample, peak_found, beats_per_minute
// cfg_ch     sink   index, data (always ready)
//
// A sample without a rate update passes through the accept, one averaging state with a
// reciprocal multiply, and the result word.
// A peak that updates the rate then sums the intervals and runs the 35-bit mean divide and the
// 18-bit rate divide, one quotient bit per cycle in the shared divider. The block takes one
// sample at a time and holds the result until it is taken.
// Reset clears the window, counters, interval history state and loads the register defaults.
`include "ecg_heart_rate_detector_unit_macros.svh"
module ecg_heart_rate_detector_unit (
    input logic          clk,
    input logic          rst_n,
    ehr_sample_if.sink   sample_ch,
    ehr_result_if.source result_ch,
    ehr_cfg_if.sink      cfg_ch
);
    import ehr_pkg::*;

    state_t                state_reg, state_next;
    logic [THRESH_W-1:0]   threshold_reg, threshold_next;
    logic [SPACING_W-1:0]  spacing_reg, spacing_next;
    logic [RATE_W-1:0]     srate_reg, srate_next;
    logic [STAMP_W-1:0]    clock_reg, clock_next;
    logic [STAMP_W-1:0]    last_peak_reg, last_peak_next;
    logic                  peak_seen_reg, peak_seen_next;
    logic [HIST_IDX_W-1:0] ring_ptr_reg, ring_ptr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [BPM_W-1:0]      bpm_reg, bpm_next;
    logic                  peak_reg, peak_next;
    logic [SAMPLE_W-1:0]   filtered_reg, filtered_next;
    logic [COUNT_W-1:0]    idx_reg, idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IVL_SUM_W-1:0]  acc_reg, acc_next;
    logic [DIV_W-1:0]      mean_reg, mean_next;

    logic [STAMP_W-1:0]    clock_plus;
    logic [STAMP_W-1:0]    gap;
    logic                  is_peak;
    logic [COUNT_W-1:0]    hist_n;
    logic [BPM_NUM_W-1:0]  bpm_num;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic                  window_push;
    logic [TAP_SUM_W-1:0]  window_sum;
    logic                  ram_we;
    logic [STAMP_W-1:0]    ram_rdata;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIV_W-1:0]      div_divisor;
    logic [DIV_W-1:0]      div_quotient;

    ehr_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (window_push),
        .sample (sample_ch.ecg_sample),
        .sum    (window_sum)
    );

    ehr_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (INTERVAL_HISTORY)
    ) u_interval_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_ptr_reg),
        .wdata (gap),
        .raddr (idx_reg[HIST_IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    ehr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign clock_plus = clock_reg + 1'b1;
    assign gap        = clock_plus - last_peak_reg;
    assign is_peak    = (sample_ch.ecg_sample > threshold_reg) &&
                        (gap > STAMP_W'(spacing_reg));
    assign hist_n     = (count_reg < COUNT_W'(INTERVAL_HISTORY)) ?
                        count_reg : COUNT_W'(INTERVAL_HISTORY);
    assign bpm_num    = BPM_NUM_W'(srate_reg) * BPM_NUM_W'(SECONDS_PER_MINUTE);
    assign avg_prod   = AVG_PROD_W'(window_sum) * AVG_PROD_W'(AVG_RECIP);

    assign sample_ch.ready            = (state_reg == S_IDLE);
    assign result_ch.valid            = (state_reg == S_OUT);
    assign result_ch.filtered_sample  = filtered_reg;
    assign result_ch.peak_found       = peak_reg;
    assign result_ch.beats_per_minute = bpm_reg;
    assign cfg_ch.ready               = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        spacing_next   = spacing_reg;
        srate_next     = srate_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_THRESHOLD: threshold_next = cfg_ch.data[THRESH_W-1:0];
                CFG_SPACING:   spacing_next   = cfg_ch.data[SPACING_W-1:0];
                CFG_RATE:      srate_next     = cfg_ch.data[RATE_W-1:0];
                default:       threshold_next = threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        last_peak_next = last_peak_reg;
        peak_seen_next = peak_seen_reg;
        ring_ptr_next  = ring_ptr_reg;
        count_next     = count_reg;
        bpm_next       = bpm_reg;
        peak_next      = peak_reg;
        filtered_next  = filtered_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        acc_next       = acc_reg;
        mean_next      = mean_reg;
        window_push    = 1'b0;
        ram_we         = 1'b0;
        div_ctrl       = '0;
        div_dividend   = '0;
        div_divisor    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    window_push = 1'b1;
                    clock_next  = clock_plus;
                    peak_next   = is_peak;
                    if (is_peak)
                    begin
                        last_peak_next = clock_plus;
                        peak_seen_next = 1'b1;
                        // The first peak only sets the time stamp.
                        if (peak_seen_reg)
                        begin
                            ram_we        = 1'b1;
                            ring_ptr_next =
                                (ring_ptr_reg == HIST_IDX_W'(INTERVAL_HISTORY - 1)) ?
                                '0 : ring_ptr_reg + 1'b1;
                            if (count_reg < COUNT_W'(COUNT_CAP))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                filtered_next = avg_prod[AVG_SHIFT +: SAMPLE_W];
                idx_next      = '0;
                rd_pend_next  = 1'b0;
                acc_next      = '0;
                if (peak_reg && (count_reg >= COUNT_W'(RATE_MIN_INTERVALS)))
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SUM:
            begin
                rd_pend_next = (idx_reg < hist_n);
                if (idx_reg < hist_n)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + IVL_SUM_W'(ram_rdata);
                end
                if (!(idx_reg < hist_n) && !rd_pend_reg)
                begin
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = DIV_CNT_W'(DIV_W);
                div_dividend   = acc_reg;
                div_divisor    = DIV_W'(hist_n);
                state_next     = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_next = div_quotient;
                    if (div_quotient == '0)
                    begin
                        bpm_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_BPM_GO;
                    end
                end
            end
            S_BPM_GO:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = DIV_CNT_W'(BPM_NUM_W);
                div_dividend   = {bpm_num, {(DIV_W - BPM_NUM_W){1'b0}}};
                div_divisor    = mean_reg;
                state_next     = S_BPM_WAIT;
            end
            S_BPM_WAIT:
            begin
                if (div_stat.done)
                begin
                    if ((div_quotient >= DIV_W'(BPM_MIN)) &&
                        (div_quotient <= DIV_W'(BPM_MAX)))
                    begin
                        bpm_next = div_quotient[BPM_W-1:0];
                    end
                    else
                    begin
                        bpm_next = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            threshold_reg <= THRESH_W'(THRESH_RESET);
            spacing_reg   <= SPACING_W'(SPACING_RESET);
            srate_reg     <= RATE_W'(RATE_RESET);
            clock_reg     <= '0;
            last_peak_reg <= '0;
            peak_seen_reg <= 1'b0;
            ring_ptr_reg  <= '0;
            count_reg     <= '0;
            bpm_reg       <= '0;
            peak_reg      <= 1'b0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            spacing_reg   <= spacing_next;
            srate_reg     <= srate_next;
            clock_reg     <= clock_next;
            last_peak_reg <= last_peak_next;
            peak_seen_reg <= peak_seen_next;
            ring_ptr_reg  <= ring_ptr_next;
            count_reg     <= count_next;
            bpm_reg       <= bpm_next;
            peak_reg      <= peak_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
        acc_reg      <= acc_next;
        mean_reg     <= mean_next;
    end

    `EHR_ASSERT_IMP(a_ready_excludes_result, clk, rst_n, sample_ch.ready, !result_ch.valid)
    `EHR_ASSERT_NXT(a_accept_blocks_input, clk, rst_n,
                    sample_ch.valid && sample_ch.ready, !sample_ch.ready)
    `EHR_ASSERT_IMP(a_done_only_when_waiting, clk, rst_n, div_stat.done,
                    state_reg == S_MEAN_WAIT || state_reg == S_BPM_WAIT)
    `EHR_ASSERT_IMP(a_start_on_idle_divider, clk, rst_n, div_ctrl.start, !div_stat.busy)
    `EHR_ASSERT_IMP(a_sum_needs_history, clk, rst_n, state_reg == S_SUM,
                    peak_reg && (count_reg >= COUNT_W'(RATE_MIN_INTERVALS)))
endmodule

FILE: design/ehr_ram.sv
// Generic single write port RAM with one registered read port.
module ehr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/ehr_window.sv
// Moving average window: a shift line of samples with a running sum.
module ehr_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [ehr_pkg::SAMPLE_W-1:0]  sample,
    output logic [ehr_pkg::TAP_SUM_W-1:0] sum
);
    import ehr_pkg::*;

    logic [SAMPLE_W-1:0]  taps_reg  [AVERAGE_TAPS];
    logic [SAMPLE_W-1:0]  taps_next [AVERAGE_TAPS];
    logic [TAP_SUM_W-1:0] sum_reg;
    logic [TAP_SUM_W-1:0] sum_next;

    always_comb
    begin
        taps_next = taps_reg;
        sum_next  = sum_reg;
        if (push)
        begin
            taps_next[0] = sample;
            for (int i = 1; i < AVERAGE_TAPS; i++)
            begin
                taps_next[i] = taps_reg[i-1];
            end
            // The exact sum always fits, so modular arithmetic is safe here.
            sum_next = sum_reg + TAP_SUM_W'(sample)
                       - TAP_SUM_W'(taps_reg[AVERAGE_TAPS-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVERAGE_TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else
        begin
            taps_reg <= taps_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;
endmodule

FILE: design/ehr_div.sv
// Shared restoring divider that retires one quotient bit per cycle.
module ehr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ehr_pkg::div_ctrl_t        ctrl,
    input  logic [ehr_pkg::DIV_W-1:0] dividend,
    input  logic [ehr_pkg::DIV_W-1:0] divisor,
    output ehr_pkg::div_stat_t        stat,
    output logic [ehr_pkg::DIV_W-1:0] quotient
);
    import ehr_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W+1:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign fits  = !diff[DIV_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            quo_next  = '0;
            cnt_next  = ctrl.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule
